// ===== sv/ptl_pkg.sv =====
// shared types and constants for the phrase trie lookup block
`timescale 1ns / 1ps

package ptl_pkg;

    localparam int KEY_W    = 16;
    localparam int PHRASE_W = 21;
    localparam int CHILD_W  = 17;
    localparam int IDX_W    = 16;

    localparam logic signed [PHRASE_W-1:0] NOT_FOUND_ID = '1;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } ptl_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NODE,
        ST_SCAN,
        ST_RESULT
    } ptl_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]           key;
        logic signed [PHRASE_W-1:0] phrase;
        logic signed [CHILD_W-1:0]  first_child;
        logic signed [CHILD_W-1:0]  last_child;
    } ptl_entry_t;

    typedef struct packed {
        logic             hit;
        logic             fail;
        logic [IDX_W-1:0] next_idx;
        logic [IDX_W-1:0] next_last;
    } ptl_step_t;

endpackage

// ===== sv/phrase_trie_lookup.sv =====
// phrase trie lookup top level: sequencer, node table and step unit
//
//  channel  | dir | tdata (low bit up)                                | tuser | tlast
//  s_*      | in  | node_addr, node_key, node_phrase, node_first_child,| cmd   | seq_last
//           |     | node_last_child, symbol (103 bits in 104)          |       |
//  m_*      | out | phrase_val (21 bits in 24)                         | found | -
//
// node write: taken in idle and written to the node table. lookup symbol: taken
// in idle while the current node is read, then its range is checked, then each
// child is scanned in turn on the single memory read port until a key matches;
// a symbol after a failed step is taken without a lookup. the final symbol adds a
// result state, held while an earlier result still waits on m_tready.
// reset puts the walk at the root; the node table itself is not cleared.
`timescale 1ns / 1ps

module phrase_trie_lookup #(
    parameter int NODE_COUNT = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // node_addr, node_key, node_phrase, node_first_child, node_last_child, symbol
    input  logic [103:0] s_tdata,
    // cmd
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // phrase_val
    output logic [23:0]  m_tdata,
    // found
    output logic         m_tuser
);
    import ptl_pkg::*;

    ptl_state_t state_reg, state_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic failed_reg, failed_next;
    logic [KEY_W-1:0] sym_reg, sym_next;
    logic seq_last_reg, seq_last_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic signed [PHRASE_W-1:0] phrase_reg, phrase_next;
    logic out_valid_reg, out_valid_next;
    logic out_found_reg, out_found_next;
    logic signed [PHRASE_W-1:0] out_phrase_reg, out_phrase_next;

    logic accept;
    logic [IDX_W-1:0] in_addr;
    logic [KEY_W-1:0] in_symbol;
    ptl_entry_t wr_data, rd_data;
    logic wr_en;
    logic [IDX_W-1:0] rd_addr;
    ptl_step_t step;
    logic out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_addr   = s_tdata[15:0];
    assign in_symbol = s_tdata[102:87];

    assign wr_data.key         = s_tdata[31:16];
    assign wr_data.phrase      = s_tdata[52:32];
    assign wr_data.first_child = s_tdata[69:53];
    assign wr_data.last_child  = s_tdata[86:70];

    assign wr_en = accept && (ptl_cmd_t'(s_tuser) == CMD_WRITE)
                   && (32'(in_addr) < 32'(NODE_COUNT));

    assign out_free = !out_valid_reg || m_tready;

    ptl_node_mem #(
        .NODE_COUNT (NODE_COUNT)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (in_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ptl_step #(
        .NODE_COUNT (NODE_COUNT)
    ) u_step (
        .is_node  (state_reg == ST_NODE),
        .entry    (rd_data),
        .cur_idx  (idx_reg),
        .last_idx (last_idx_reg),
        .sym      (sym_reg),
        .step     (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        seq_last_reg   <= seq_last_next;
        idx_reg        <= idx_next;
        last_idx_reg   <= last_idx_next;
        phrase_reg     <= phrase_next;
        out_found_reg  <= out_found_next;
        out_phrase_reg <= out_phrase_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        failed_next     = failed_reg;
        sym_next        = sym_reg;
        seq_last_next   = seq_last_reg;
        idx_next        = idx_reg;
        last_idx_next   = last_idx_reg;
        phrase_next     = phrase_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_phrase_next = out_phrase_reg;
        rd_addr         = step.next_idx;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = cursor_reg;
                if (accept && ptl_cmd_t'(s_tuser) == CMD_LOOKUP)
                begin
                    sym_next      = in_symbol;
                    seq_last_next = s_tlast;
                    if (failed_reg)
                    begin
                        if (s_tlast)
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                    else
                    begin
                        state_next = ST_NODE;
                    end
                end
            end
            ST_NODE:
            begin
                if (step.fail)
                begin
                    failed_next = 1'b1;
                    state_next  = seq_last_reg ? ST_RESULT : ST_IDLE;
                end
                else
                begin
                    idx_next      = step.next_idx;
                    last_idx_next = step.next_last;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step.hit)
                begin
                    // matched entry is already on the read port, keep its phrase
                    cursor_next = idx_reg;
                    phrase_next = rd_data.phrase;
                    state_next  = seq_last_reg ? ST_RESULT : ST_IDLE;
                end
                else if (step.fail)
                begin
                    failed_next = 1'b1;
                    state_next  = seq_last_reg ? ST_RESULT : ST_IDLE;
                end
                else
                begin
                    idx_next = step.next_idx;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = !failed_reg;
                    out_phrase_next = failed_reg ? NOT_FOUND_ID : phrase_reg;
                    cursor_next     = '0;
                    failed_next     = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {3'b000, out_phrase_reg};

`ifndef SYNTH
    // a result leaving the sequencer always shows up on the output
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free) |=> m_tvalid)
        else $error("result not presented");

    // each sequence starts again from the root with a clean path
    a_walk_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free) |=> (cursor_reg == '0 && !failed_reg))
        else $error("walk not returned to root");

    // a failed path is never scanned further
    a_no_scan_failed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_NODE) |-> !failed_reg)
        else $error("scan on failed path");

    // scan pointer stays inside the child range
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> idx_reg <= last_idx_reg)
        else $error("scan pointer beyond last child");

    // not-found results carry the not-found phrase id
    a_not_found_id: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tdata[20:0] == NOT_FOUND_ID)
        else $error("not-found result with phrase id");
`endif

endmodule

// ===== sv/ptl_node_mem.sv =====
// node table: one write port, one registered read port
`timescale 1ns / 1ps

module ptl_node_mem #(
    parameter int NODE_COUNT = 65536
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ptl_pkg::IDX_W-1:0] wr_addr,
    input  ptl_pkg::ptl_entry_t     wr_data,
    input  logic [ptl_pkg::IDX_W-1:0] rd_addr,
    output ptl_pkg::ptl_entry_t     rd_data
);
    import ptl_pkg::*;

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    ptl_entry_t mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(wr_addr)] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[AW'(rd_addr)];
    end

endmodule

// ===== sv/ptl_step.sv =====
// step unit: range check of a node entry, or key compare of one child
`timescale 1ns / 1ps

module ptl_step #(
    parameter int NODE_COUNT = 65536
) (
    input  logic                      is_node,
    input  ptl_pkg::ptl_entry_t       entry,
    input  logic [ptl_pkg::IDX_W-1:0] cur_idx,
    input  logic [ptl_pkg::IDX_W-1:0] last_idx,
    input  logic [ptl_pkg::KEY_W-1:0] sym,
    output ptl_pkg::ptl_step_t        step
);
    import ptl_pkg::*;

    localparam logic [31:0] NODE_LIMIT = 32'(NODE_COUNT);

    logic [IDX_W:0] inc;

    assign inc = {1'b0, cur_idx} + (IDX_W+1)'(1);

    always_comb
    begin
        step = '0;
        if (is_node)
        begin
            if (entry.first_child < 0 || entry.last_child < entry.first_child
                || 32'($unsigned(entry.first_child)) >= NODE_LIMIT)
            begin
                step.fail = 1'b1;
            end
            else
            begin
                step.next_idx  = entry.first_child[IDX_W-1:0];
                step.next_last = entry.last_child[IDX_W-1:0];
            end
        end
        else
        begin
            step.next_last = last_idx;
            if (entry.key == sym)
            begin
                step.hit = 1'b1;
            end
            else if (cur_idx == last_idx || 32'(inc) >= NODE_LIMIT)
            begin
                step.fail = 1'b1;
            end
            else
            begin
                step.next_idx = inc[IDX_W-1:0];
            end
        end
    end

endmodule
